// ===== rtl/core/yuv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Shared types, coefficients and arithmetic helpers for the YUV 4:2:2 pair
// to RGB888 converter.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned DiffW  = 8;
	localparam int unsigned CoefW  = 11;
	localparam int unsigned ProdW  = 19;
	localparam int unsigned TermW  = 11;
	localparam int unsigned AccW   = 12;

	localparam logic signed [CoefW-1:0] CoefRV = 11'sd718;
	localparam logic signed [CoefW-1:0] CoefGU = -11'sd176;
	localparam logic signed [CoefW-1:0] CoefGV = -11'sd366;
	localparam logic signed [CoefW-1:0] CoefBU = 11'sd907;

	localparam int unsigned ChromaShift = 7;
	localparam int unsigned LumaShift   = 2;
	localparam logic [ChanW-1:0] ChanMax = 8'd255;

	typedef struct packed {
		logic signed [TermW-1:0] red;
		logic signed [TermW-1:0] green;
		logic signed [TermW-1:0] blue;
	} chroma_terms_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} rgb_pixel_t;

	// c - 128 as a signed byte: flip the top bit
	function automatic logic signed [DiffW-1:0] chroma_offset(input logic [ChanW-1:0] c);
		return {~c[ChanW-1], c[ChanW-2:0]};
	endfunction

	// product / 128, rounded toward zero
	function automatic logic signed [TermW-1:0] div128_trunc(
		input logic signed [ProdW-1:0] p
	);
		logic signed [ProdW-1:0] adj;
		logic signed [ProdW-1:0] sh;
		adj = p[ProdW-1] ? (p + ProdW'((1 << ChromaShift) - 1)) : p;
		sh  = adj >>> ChromaShift;
		return sh[TermW-1:0];
	endfunction

	// (4*Y + terms) / 4 rounded toward zero, then clamped to 0..255
	function automatic logic [ChanW-1:0] finish_chan(
		input logic [ChanW-1:0]        y,
		input logic signed [TermW-1:0] t
	);
		logic signed [AccW-1:0] acc;
		logic signed [AccW-1:0] adj;
		logic signed [AccW-1:0] q;
		acc = $signed({2'b00, y, 2'b00}) + AccW'(t);
		adj = acc[AccW-1] ? (acc + AccW'((1 << LumaShift) - 1)) : acc;
		q   = adj >>> LumaShift;
		if (q[AccW-1]) begin
			return '0;
		end else if (q[AccW-2:0] > (AccW-1)'(ChanMax)) begin
			return ChanMax;
		end else begin
			return q[ChanW-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/yuv2rgb_chroma.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_chroma
// Chroma contributions shared by both pixels of a pair: one constant
// multiply per coefficient, scaled by 1/128 with truncation toward zero.
// ----------------------------------------------------------------------------
module yuv2rgb_chroma
	import yuv2rgb_pkg::*;
(
	input  logic [ChanW-1:0] u,
	input  logic [ChanW-1:0] v,
	output chroma_terms_t    terms
);

	logic signed [DiffW-1:0] du;
	logic signed [DiffW-1:0] dv;
	logic signed [ProdW-1:0] prod_rv;
	logic signed [ProdW-1:0] prod_gu;
	logic signed [ProdW-1:0] prod_gv;
	logic signed [ProdW-1:0] prod_bu;
	logic signed [TermW-1:0] term_gu;
	logic signed [TermW-1:0] term_gv;

	assign du = chroma_offset(u);
	assign dv = chroma_offset(v);

	assign prod_rv = dv * CoefRV;
	assign prod_gu = du * CoefGU;
	assign prod_gv = dv * CoefGV;
	assign prod_bu = du * CoefBU;

	assign term_gu = div128_trunc(prod_gu);
	assign term_gv = div128_trunc(prod_gv);

	// green sum stays within +/-542
	assign terms.red   = div128_trunc(prod_rv);
	assign terms.green = term_gu + term_gv;
	assign terms.blue  = div128_trunc(prod_bu);

endmodule

// ===== rtl/core/yuv2rgb_pixel.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_pixel
// Combines one luma sample with the shared chroma terms into a clamped
// RGB888 pixel.
// ----------------------------------------------------------------------------
module yuv2rgb_pixel
	import yuv2rgb_pkg::*;
(
	input  logic [ChanW-1:0] y,
	input  chroma_terms_t    terms,
	output rgb_pixel_t       pix
);

	assign pix.red   = finish_chan(y, terms.red);
	assign pix.green = finish_chan(y, terms.green);
	assign pix.blue  = finish_chan(y, terms.blue);

endmodule

// ===== rtl/core/yuv422_pair_to_rgb_core.sv =====
// ----------------------------------------------------------------------------
// yuv422_pair_to_rgb_core
// Converts one packed YUV 4:2:2 pixel pair into two RGB888 pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock and returns its two RGB pixels:
// the words land in an input register, the chroma multiplies, luma sums and
// clamps run in one pass, and the six channels are held in a result register.
// The input register loads when empty or when the result register advances,
// so a full pair per cycle is sustained while out_stall is low; with
// out_stall high the block holds up to two pairs before raising in_stall.
// There is no configuration and no state beyond the pipeline.
module yuv422_pair_to_rgb_core
	import yuv2rgb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             in_valid,
	output logic             in_stall,
	input  logic [15:0]      first_word,
	input  logic [15:0]      second_word,

	output logic             out_valid,
	input  logic             out_stall,
	output logic [ChanW-1:0] blue_first,
	output logic [ChanW-1:0] green_first,
	output logic [ChanW-1:0] red_first,
	output logic [ChanW-1:0] blue_second,
	output logic [ChanW-1:0] green_second,
	output logic [ChanW-1:0] red_second
);

	logic          valid_s1;
	logic [15:0]   first_word_s1;
	logic [15:0]   second_word_s1;
	logic          valid_s2;
	rgb_pixel_t    pix_first_s2;
	rgb_pixel_t    pix_second_s2;

	logic          advance;
	chroma_terms_t terms;
	rgb_pixel_t    pix_first;
	rgb_pixel_t    pix_second;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			first_word_s1  <= first_word;
			second_word_s1 <= second_word;
		end
	end

	yuv2rgb_chroma u_chroma (
		.u     (first_word_s1[7:0]),
		.v     (second_word_s1[7:0]),
		.terms (terms)
	);

	yuv2rgb_pixel u_pix_first (
		.y     (first_word_s1[15:8]),
		.terms (terms),
		.pix   (pix_first)
	);

	yuv2rgb_pixel u_pix_second (
		.y     (second_word_s1[15:8]),
		.terms (terms),
		.pix   (pix_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pix_first_s2  <= pix_first;
			pix_second_s2 <= pix_second;
		end
	end

	assign out_valid    = valid_s2;
	assign blue_first   = pix_first_s2.blue;
	assign green_first  = pix_first_s2.green;
	assign red_first    = pix_first_s2.red;
	assign blue_second  = pix_second_s2.blue;
	assign green_second = pix_second_s2.green;
	assign red_second   = pix_second_s2.red;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while pipeline has room");

	a_beat_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (valid_s1 && second_word_s1 == $past(second_word)
			&& first_word_s1 == $past(first_word)))
		else $error("accepted beat not captured in input register");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("pair lost between input and result registers");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(first_word_s1)
			&& $stable(second_word_s1)))
		else $error("input register changed while blocked");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks yuv422_pair_to_rgb_core beat by beat: each accepted pixel pair is
// converted by a local integer predictor, and every result beat is compared
// channel by channel with the oldest prediction. Corner pairs come first,
// then random pairs at full rate, under back-pressure and with random gaps.
// ----------------------------------------------------------------------------
module tb;
	import yuv2rgb_pkg::*;

	localparam int CycleLimit = 300000;
	localparam int DrainCycles = 10;

	typedef struct packed {
		rgb_pixel_t pix1;
		rgb_pixel_t pix2;
	} rgb_pair_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [15:0]      first_word;
	logic [15:0]      second_word;
	logic             out_valid;
	logic             out_stall;
	logic [ChanW-1:0] blue_first;
	logic [ChanW-1:0] green_first;
	logic [ChanW-1:0] red_first;
	logic [ChanW-1:0] blue_second;
	logic [ChanW-1:0] green_second;
	logic [ChanW-1:0] red_second;

	rgb_pair_t pending_pairs[$];
	rgb_pair_t got_pair;
	rgb_pair_t want_pair;
	int        mismatches = 0;
	int        cycle_count = 0;
	int        stall_left = 0;
	bit        send_gaps_on = 1'b0;
	bit        stall_gaps_on = 1'b0;

	// byte order of rgb_pair_t from the LSB up
	string ChanNames[6] = '{"blue_second", "green_second", "red_second",
		"blue_first", "green_first", "red_first"};

	always #5 clk = ~clk;

	yuv422_pair_to_rgb_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_word   (first_word),
		.second_word  (second_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue_first   (blue_first),
		.green_first  (green_first),
		.red_first    (red_first),
		.blue_second  (blue_second),
		.green_second (green_second),
		.red_second   (red_second)
	);

	// k*(c-128)/128, truncated toward zero
	function automatic int chroma_term(input int k, input logic [7:0] c);
		return (k * (int'(c) - 128)) / 128;
	endfunction

	function automatic logic [7:0] clamp_chan(input logic [7:0] y, input int term);
		int v;
		v = (4 * int'(y) + term) / 4;
		if (v > 255)
			v = 255;
		if (v < 0)
			v = 0;
		return v[7:0];
	endfunction

	function automatic rgb_pair_t yuv_pair_to_rgb(input logic [15:0] fw, input logic [15:0] sw);
		rgb_pair_t p;
		int        tr;
		int        tg;
		int        tb_;
		tr  = chroma_term(718, sw[7:0]);
		tg  = chroma_term(-176, fw[7:0]) + chroma_term(-366, sw[7:0]);
		tb_ = chroma_term(907, fw[7:0]);
		p.pix1.red   = clamp_chan(fw[15:8], tr);
		p.pix1.green = clamp_chan(fw[15:8], tg);
		p.pix1.blue  = clamp_chan(fw[15:8], tb_);
		p.pix2.red   = clamp_chan(sw[15:8], tr);
		p.pix2.green = clamp_chan(sw[15:8], tg);
		p.pix2.blue  = clamp_chan(sw[15:8], tb_);
		return p;
	endfunction

	// mostly short, a few long
	function automatic int rand_gap(input bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// luma and chroma biased towards the clamp limits and the chroma midpoint
	function automatic logic [15:0] random_word();
		logic [7:0] y;
		logic [7:0] c;
		y = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			y = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 3) == 0)
			c = $urandom_range(0, 1) ? (8'd126 + 8'($urandom_range(0, 4)))
				: ($urandom_range(0, 1) ? 8'hFF : 8'h00);
		return {y, c};
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= 1'b0;
			stall_left <= rand_gap(stall_gaps_on);
		end
	end

	// result check first, then record the beat accepted at this edge
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got_pair = '{pix1: '{red: red_first, green: green_first, blue: blue_first},
				pix2: '{red: red_second, green: green_second, blue: blue_second}};
			if (pending_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result beat %h", $realtime, got_pair);
			end else begin
				want_pair = pending_pairs.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (got_pair[i*8 +: 8] !== want_pair[i*8 +: 8]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: %s expected %0d got %0d", $realtime,
								ChanNames[i], want_pair[i*8 +: 8], got_pair[i*8 +: 8]);
					end
				end
			end
		end
		if (arst_n && in_valid === 1'b1 && in_stall === 1'b0)
			pending_pairs.push_back(yuv_pair_to_rgb(first_word, second_word));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_pair(input logic [15:0] fw, input logic [15:0] sw);
		int gap;
		gap = rand_gap(send_gaps_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		first_word  <= fw;
		second_word <= sw;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic send_random_pairs(input int count);
		for (int i = 0; i < count; i++)
			send_pair(random_word(), random_word());
	endtask

	// neutral chroma, saturation both ways, truncation just either side of 128
	task automatic test_corner_pairs();
		logic [31:0] pairs[18];
		pairs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080, 32'hFF80_0080,
			32'h00FF_FF00, 32'hFF00_00FF, 32'h00FF_00FF, 32'hFF00_FF00,
			32'h807F_807F, 32'h8081_8081, 32'h017F_017F, 32'h0181_FE7F,
			32'hFEFF_FEFF, 32'h0100_0100, 32'hC040_40C0, 32'h5555_AAAA,
			32'hAAAA_5555, 32'h7F80_8080};
		send_gaps_on  = 1'b1;
		stall_gaps_on = 1'b1;
		foreach (pairs[i])
			send_pair(pairs[i][31:16], pairs[i][15:0]);
	endtask

	task automatic test_streaming();
		send_gaps_on  = 1'b0;
		stall_gaps_on = 1'b0;
		send_random_pairs(150);
	endtask

	task automatic test_backpressure();
		send_gaps_on  = 1'b0;
		stall_gaps_on = 1'b1;
		send_random_pairs(150);
	endtask

	task automatic test_random_gaps();
		send_gaps_on  = 1'b1;
		stall_gaps_on = 1'b1;
		send_random_pairs(250);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		first_word  = '0;
		second_word = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_corner_pairs();
		test_streaming();
		test_backpressure();
		test_random_gaps();

		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/yuv2rgb_pkg.sv
rtl/core/yuv2rgb_chroma.sv
rtl/core/yuv2rgb_pixel.sv
rtl/core/yuv422_pair_to_rgb_core.sv
tb/tb.sv
